FILE: hw/rtl/hbs_pkg.sv
// Shared widths, codes and types for the height-map bilinear sampler.
package hbs_pkg;

    // Word field widths.
    localparam int COORD_W    = 32;
    localparam int HEIGHT_W   = 24;
    localparam int FRAC_W     = 16;
    localparam int GRID_W     = 9;

    // Grid coordinate carries 24 fraction bits; the kept fraction is its top 16.
    localparam int GRID_FRAC_W = 24;

    // Height store: 16-bit linear address, split over two banks by address parity.
    localparam int STORE_AW   = 16;
    localparam int BANK_AW    = STORE_AW - 1;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Smallest grid extent and register reset values.
    localparam int MIN_GRID   = 2;
    localparam logic [CFG_DATA_W-1:0] INV_RESET  = 32'd65536;
    localparam logic [GRID_W-1:0]     GRID_RESET = 9'd256;

    // Item command codes.
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_INV_X    = 3'd2,
        CFG_INV_Y    = 3'd3,
        CFG_COLS     = 3'd4,
        CFG_ROWS     = 3'd5
    } cfg_idx_t;

    // The four neighbouring heights of one query.
    typedef struct packed {
        logic signed [HEIGHT_W-1:0] h00;
        logic signed [HEIGHT_W-1:0] h10;
        logic signed [HEIGHT_W-1:0] h01;
        logic signed [HEIGHT_W-1:0] h11;
    } corners_t;

endpackage

FILE: hw/rtl/heightmap_bilinear_sampler_unit.sv
// Height-map bilinear sampler: sample writes and point queries in one word stream.
// A query passes the axis units, the address stage, the bank read and the blend stages.
// Throughput: one word per cycle unless stalled, writes and queries alike; the four
// neighbours come from four single-read banks (two parity banks, each held twice),
// one read each. Reset covers config registers and valid flags, not the store.
module heightmap_bilinear_sampler_unit #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic [hbs_pkg::STORE_AW-1:0]         write_index,
    input  logic signed [hbs_pkg::HEIGHT_W-1:0]  sample_height,
    input  logic signed [hbs_pkg::COORD_W-1:0]   query_x,
    input  logic signed [hbs_pkg::COORD_W-1:0]   query_y,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [hbs_pkg::HEIGHT_W-1:0]  height_out,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int IX_W  = $clog2(MAX_COLS);
    localparam int IY_W  = $clog2(MAX_ROWS);
    localparam int AW    = hbs_pkg::STORE_AW;
    localparam int FW    = hbs_pkg::FRAC_W;
    localparam int ADDR_STG = 6;

    typedef struct packed {
        hbs_pkg::cmd_t                 cmd;
        logic [AW-1:0]                 widx;
        logic [hbs_pkg::HEIGHT_W-1:0]  wdata;
    } item_t;

    // Configuration registers.
    logic signed [hbs_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [hbs_pkg::COORD_W-1:0] origin_y_reg;
    logic [hbs_pkg::COORD_W-1:0]        inv_x_reg;
    logic [hbs_pkg::COORD_W-1:0]        inv_y_reg;
    logic [hbs_pkg::GRID_W-1:0]         cols_reg;
    logic [hbs_pkg::GRID_W-1:0]         rows_reg;

    logic [COL_W-1:0] cols_sat;
    logic [ROW_W-1:0] rows_sat;
    logic [IX_W-1:0]  lim_x;
    logic [IY_W-1:0]  lim_y;

    logic adv;

    // Item pipeline up to the store access stage.
    logic  [ADDR_STG:1] v_reg;
    item_t              item_reg [1:ADDR_STG];
    item_t              item_next;

    // Axis outputs.
    logic [IX_W-1:0] i0;
    logic [IY_W-1:0] j0;
    logic [FW-1:0]   tx5;
    logic [FW-1:0]   ty5;

    // Address stage.
    logic [IY_W:0]            j0p1;
    logic [IY_W+COL_W-1:0]    jprod;
    logic [IY_W+COL_W:0]      jprod1;
    logic [AW-1:0]            jc_reg;
    logic [AW-1:0]            jc1_reg;
    logic [AW-1:0]            i0_reg;
    logic [AW-1:0]            i0p1_reg;
    logic [FW-1:0]            tx6_reg;
    logic [FW-1:0]            ty6_reg;
    logic [AW-1:0]            a00;
    logic [AW-1:0]            a10;
    logic [AW-1:0]            a01;
    logic [AW-1:0]            a11;
    logic [AW-1:0]            even_a;
    logic [AW-1:0]            odd_a;
    logic [AW-1:0]            even_b;
    logic [AW-1:0]            odd_b;
    logic                     wr_go;
    logic                     qv7_next;

    // Read data stage.
    logic                     qv7_reg;
    logic                     sela_reg;
    logic                     selb_reg;
    logic [FW-1:0]            tx7_reg;
    logic [FW-1:0]            ty7_reg;
    logic [hbs_pkg::HEIGHT_W-1:0] a0_data;
    logic [hbs_pkg::HEIGHT_W-1:0] a1_data;
    logic [hbs_pkg::HEIGHT_W-1:0] b0_data;
    logic [hbs_pkg::HEIGHT_W-1:0] b1_data;
    hbs_pkg::corners_t        corners;

    // The whole pipeline moves unless a finished word is waiting and stalled.
    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            inv_x_reg    <= hbs_pkg::INV_RESET;
            inv_y_reg    <= hbs_pkg::INV_RESET;
            cols_reg     <= hbs_pkg::GRID_RESET;
            rows_reg     <= hbs_pkg::GRID_RESET;
        end
        else if (cfg_valid)
        begin
            case (hbs_pkg::cfg_idx_t'(cfg_index))
                hbs_pkg::CFG_ORIGIN_X: origin_x_reg <= $signed(cfg_data);
                hbs_pkg::CFG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data);
                hbs_pkg::CFG_INV_X:    inv_x_reg    <= cfg_data;
                hbs_pkg::CFG_INV_Y:    inv_y_reg    <= cfg_data;
                hbs_pkg::CFG_COLS:     cols_reg     <= cfg_data[hbs_pkg::GRID_W-1:0];
                hbs_pkg::CFG_ROWS:     rows_reg     <= cfg_data[hbs_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid extents saturated into their legal range, and the last full cell.
    always_comb
    begin
        if (int'(cols_reg) < hbs_pkg::MIN_GRID)
        begin
            cols_sat = COL_W'(hbs_pkg::MIN_GRID);
        end
        else if (int'(cols_reg) > MAX_COLS)
        begin
            cols_sat = COL_W'(MAX_COLS);
        end
        else
        begin
            cols_sat = COL_W'(cols_reg);
        end

        if (int'(rows_reg) < hbs_pkg::MIN_GRID)
        begin
            rows_sat = ROW_W'(hbs_pkg::MIN_GRID);
        end
        else if (int'(rows_reg) > MAX_ROWS)
        begin
            rows_sat = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows_sat = ROW_W'(rows_reg);
        end
    end

    assign lim_x = IX_W'(cols_sat - COL_W'(hbs_pkg::MIN_GRID));
    assign lim_y = IY_W'(rows_sat - ROW_W'(hbs_pkg::MIN_GRID));

    // Item pipeline: command and write payload follow the coordinate units.
    assign item_next.cmd   = hbs_pkg::cmd_t'(command);
    assign item_next.widx  = write_index;
    assign item_next.wdata = sample_height;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[ADDR_STG-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[1] <= item_next;
            for (int k = 2; k <= ADDR_STG; k++)
            begin
                item_reg[k] <= item_reg[k-1];
            end
        end
    end

    // Coordinate units, one per axis.
    hbs_axis #(
        .IX_W (IX_W)
    ) u_axis_x (
        .clk    (clk),
        .en     (adv),
        .point  (query_x),
        .origin (origin_x_reg),
        .inv    (inv_x_reg),
        .lim    (lim_x),
        .idx    (i0),
        .frac   (tx5)
    );

    hbs_axis #(
        .IX_W (IY_W)
    ) u_axis_y (
        .clk    (clk),
        .en     (adv),
        .point  (query_y),
        .origin (origin_y_reg),
        .inv    (inv_y_reg),
        .lim    (lim_y),
        .idx    (j0),
        .frac   (ty5)
    );

    // Row offsets of the lower and upper neighbour rows.
    assign j0p1   = (IY_W + 1)'(j0) + (IY_W + 1)'(1);
    assign jprod  = j0 * cols_sat;
    assign jprod1 = j0p1 * cols_sat;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            jc_reg   <= AW'(jprod);
            jc1_reg  <= AW'(jprod1);
            i0_reg   <= AW'(i0);
            i0p1_reg <= AW'(i0) + AW'(1);
            tx6_reg  <= tx5;
            ty6_reg  <= ty5;
        end
    end

    // Four neighbour addresses, wrapping at the store size.
    assign a00 = i0_reg + jc_reg;
    assign a10 = i0p1_reg + jc_reg;
    assign a01 = i0_reg + jc1_reg;
    assign a11 = i0p1_reg + jc1_reg;

    // Horizontal neighbours differ in parity, so each pair splits over two banks.
    assign even_a = a00[0] ? a10 : a00;
    assign odd_a  = a00[0] ? a00 : a10;
    assign even_b = a01[0] ? a11 : a01;
    assign odd_b  = a01[0] ? a01 : a11;

    // Writes go to both copies at the same stage as query reads, keeping order.
    assign wr_go    = adv && v_reg[ADDR_STG] && (item_reg[ADDR_STG].cmd == hbs_pkg::CMD_WRITE);
    assign qv7_next = v_reg[ADDR_STG] && (item_reg[ADDR_STG].cmd == hbs_pkg::CMD_QUERY);

    hbs_bank u_bank_a0 (
        .clk     (clk),
        .wr_en   (wr_go && !item_reg[ADDR_STG].widx[0]),
        .wr_addr (item_reg[ADDR_STG].widx[AW-1:1]),
        .wr_data (item_reg[ADDR_STG].wdata),
        .rd_en   (adv),
        .rd_addr (even_a[AW-1:1]),
        .rd_data (a0_data)
    );

    hbs_bank u_bank_a1 (
        .clk     (clk),
        .wr_en   (wr_go && item_reg[ADDR_STG].widx[0]),
        .wr_addr (item_reg[ADDR_STG].widx[AW-1:1]),
        .wr_data (item_reg[ADDR_STG].wdata),
        .rd_en   (adv),
        .rd_addr (odd_a[AW-1:1]),
        .rd_data (a1_data)
    );

    hbs_bank u_bank_b0 (
        .clk     (clk),
        .wr_en   (wr_go && !item_reg[ADDR_STG].widx[0]),
        .wr_addr (item_reg[ADDR_STG].widx[AW-1:1]),
        .wr_data (item_reg[ADDR_STG].wdata),
        .rd_en   (adv),
        .rd_addr (even_b[AW-1:1]),
        .rd_data (b0_data)
    );

    hbs_bank u_bank_b1 (
        .clk     (clk),
        .wr_en   (wr_go && item_reg[ADDR_STG].widx[0]),
        .wr_addr (item_reg[ADDR_STG].widx[AW-1:1]),
        .wr_data (item_reg[ADDR_STG].wdata),
        .rd_en   (adv),
        .rd_addr (odd_b[AW-1:1]),
        .rd_data (b1_data)
    );

    // Side data that travels alongside the store reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv7_reg <= 1'b0;
        end
        else if (adv)
        begin
            qv7_reg <= qv7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sela_reg <= a00[0];
            selb_reg <= a01[0];
            tx7_reg  <= tx6_reg;
            ty7_reg  <= ty6_reg;
        end
    end

    // Put the bank outputs back in neighbour order.
    assign corners.h00 = $signed(sela_reg ? a1_data : a0_data);
    assign corners.h10 = $signed(sela_reg ? a0_data : a1_data);
    assign corners.h01 = $signed(selb_reg ? b1_data : b0_data);
    assign corners.h11 = $signed(selb_reg ? b0_data : b1_data);

    hbs_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (qv7_reg),
        .corners (corners),
        .tx      (tx7_reg),
        .ty      (ty7_reg),
        .vld_out (out_valid),
        .height  (height_out)
    );

endmodule

FILE: hw/rtl/hbs_bank.sv
// One bank of the height store: one write port, one registered read port.
module hbs_bank
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [hbs_pkg::BANK_AW-1:0]   wr_addr,
    input  logic [hbs_pkg::HEIGHT_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [hbs_pkg::BANK_AW-1:0]   rd_addr,
    output logic [hbs_pkg::HEIGHT_W-1:0]  rd_data
);

    logic [hbs_pkg::HEIGHT_W-1:0] mem [0:hbs_pkg::BANK_DEPTH-1];
    logic [hbs_pkg::HEIGHT_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while the pipeline is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/hbs_axis.sv
// Grid coordinate of one axis: (point - origin) * reciprocal spacing, split into
// a clamped cell index and a 16-bit fraction. Five register stages.
module hbs_axis #(
    parameter int IX_W = 8
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [hbs_pkg::COORD_W-1:0]  point,
    input  logic signed [hbs_pkg::COORD_W-1:0]  origin,
    input  logic [hbs_pkg::COORD_W-1:0]         inv,
    input  logic [IX_W-1:0]                     lim,
    output logic [IX_W-1:0]                     idx,
    output logic [hbs_pkg::FRAC_W-1:0]          frac
);

    localparam int MAG_W  = hbs_pkg::COORD_W + 1;
    localparam int HALF_W = hbs_pkg::COORD_W / 2;
    localparam int PP_W   = MAG_W + HALF_W;
    localparam int PROD_W = MAG_W + hbs_pkg::COORD_W;
    localparam int IW     = PROD_W - hbs_pkg::GRID_FRAC_W;
    localparam int FR_HI  = hbs_pkg::GRID_FRAC_W - 1;
    localparam int FR_LO  = hbs_pkg::GRID_FRAC_W - hbs_pkg::FRAC_W;

    logic [MAG_W-1:0]  d_reg;
    logic [MAG_W-1:0]  d_next;
    logic              neg_b_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  mag_next;
    logic              neg_c_reg;
    logic [PP_W-1:0]   pp_lo_reg;
    logic [PP_W-1:0]   pp_hi_reg;
    logic [PP_W-1:0]   pp_lo_next;
    logic [PP_W-1:0]   pp_hi_next;
    logic              neg_d_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [IW-1:0]     whole;
    logic [hbs_pkg::GRID_FRAC_W-1:0] low_neg;
    logic [IX_W-1:0]   idx_reg;
    logic [IX_W-1:0]   idx_next;
    logic [hbs_pkg::FRAC_W-1:0] frac_reg;
    logic [hbs_pkg::FRAC_W-1:0] frac_next;

    // Exact 33-bit offset from the grid origin.
    assign d_next = {point[hbs_pkg::COORD_W-1], point} - {origin[hbs_pkg::COORD_W-1], origin};

    // Magnitude of the offset; the sign travels alongside.
    assign mag_next = d_reg[MAG_W-1] ? (MAG_W'(0) - d_reg) : d_reg;

    // The 33 x 32 product is formed as two 33 x 16 partial products.
    assign pp_lo_next = mag_reg * inv[HALF_W-1:0];
    assign pp_hi_next = mag_reg * inv[hbs_pkg::COORD_W-1:HALF_W];
    assign prod_next  = PROD_W'(pp_lo_reg) + {pp_hi_reg, {HALF_W{1'b0}}};

    // Split into index and fraction. A negative offset lands on cell zero but
    // keeps the fraction of its own two's complement value.
    assign whole   = prod_reg[PROD_W-1:hbs_pkg::GRID_FRAC_W];
    assign low_neg = hbs_pkg::GRID_FRAC_W'(0) - prod_reg[hbs_pkg::GRID_FRAC_W-1:0];

    always_comb
    begin
        if (neg_d_reg)
        begin
            frac_next = low_neg[FR_HI:FR_LO];
            idx_next  = '0;
        end
        else
        begin
            frac_next = prod_reg[FR_HI:FR_LO];
            if (whole > IW'(lim))
            begin
                idx_next = lim;
            end
            else
            begin
                idx_next = whole[IX_W-1:0];
            end
        end
    end

    // Pipeline registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            neg_b_reg <= d_reg[MAG_W-1];
            mag_reg   <= mag_next;
            neg_c_reg <= neg_b_reg;
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            neg_d_reg <= neg_c_reg;
            prod_reg  <= prod_next;
            idx_reg   <= idx_next;
            frac_reg  <= frac_next;
        end
    end

    assign idx  = idx_reg;
    assign frac = frac_reg;

endmodule

FILE: hw/rtl/hbs_blend.sv
// Bilinear blend of four heights, exact until the final floor by 2^32.
// Five register stages, the last of which is the output word register.
module hbs_blend
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 vld_in,
    input  hbs_pkg::corners_t                    corners,
    input  logic [hbs_pkg::FRAC_W-1:0]           tx,
    input  logic [hbs_pkg::FRAC_W-1:0]           ty,
    output logic                                 vld_out,
    output logic signed [hbs_pkg::HEIGHT_W-1:0]  height
);

    localparam int HW    = hbs_pkg::HEIGHT_W;
    localparam int FW    = hbs_pkg::FRAC_W;
    localparam int DW    = HW + 1;
    localparam int ROW_W = DW + FW + 1;
    localparam int DH_W  = ROW_W - FW;
    localparam int P1_W  = DH_W + FW + 1;
    localparam int TOT_W = ROW_W + 2 * FW + 2;
    localparam int RES_LO = 2 * FW;

    logic [3:0] vld_reg;
    logic       out_vld_reg;

    logic signed [HW-1:0]    h00_reg;
    logic signed [HW-1:0]    h01_reg;
    logic signed [DW-1:0]    dlo_reg;
    logic signed [DW-1:0]    dhi_reg;
    logic signed [DW-1:0]    dlo_next;
    logic signed [DW-1:0]    dhi_next;
    logic [FW-1:0]           tx_i_reg;
    logic [FW-1:0]           ty_i_reg;

    logic signed [ROW_W-1:0] mlo;
    logic signed [ROW_W-1:0] mhi;
    logic signed [ROW_W-1:0] lo_reg;
    logic signed [ROW_W-1:0] hi_reg;
    logic signed [ROW_W-1:0] lo_next;
    logic signed [ROW_W-1:0] hi_next;
    logic [FW-1:0]           ty_j_reg;

    logic signed [ROW_W-1:0] lo_k_reg;
    logic signed [ROW_W-1:0] dd_reg;
    logic signed [ROW_W-1:0] dd_next;
    logic [FW-1:0]           ty_k_reg;

    logic signed [ROW_W-1:0] lo_l_reg;
    logic signed [P1_W-1:0]  p1_reg;
    logic signed [P1_W-1:0]  p1_next;
    logic [2*FW-1:0]         p0_reg;
    logic [2*FW-1:0]         p0_next;

    logic [TOT_W-1:0]        total;
    logic [HW-1:0]           height_reg;

    // Differences along x: a row blend is h0 * 2^16 + (h1 - h0) * t.
    assign dlo_next = {corners.h10[HW-1], corners.h10} - {corners.h00[HW-1], corners.h00};
    assign dhi_next = {corners.h11[HW-1], corners.h11} - {corners.h01[HW-1], corners.h01};

    // Row blends.
    assign mlo     = dlo_reg * $signed({1'b0, tx_i_reg});
    assign mhi     = dhi_reg * $signed({1'b0, tx_i_reg});
    assign lo_next = {{(ROW_W-HW-FW){h00_reg[HW-1]}}, h00_reg, {FW{1'b0}}} + mlo;
    assign hi_next = {{(ROW_W-HW-FW){h01_reg[HW-1]}}, h01_reg, {FW{1'b0}}} + mhi;

    // Difference between the rows.
    assign dd_next = hi_reg - lo_reg;

    // Column blend: the row difference times ty, cut into two partial products.
    assign p1_next = $signed(dd_reg[ROW_W-1:FW]) * $signed({1'b0, ty_k_reg});
    assign p0_next = dd_reg[FW-1:0] * ty_k_reg;

    // Sum and floor by 2^32; the arithmetic shift rounds toward minus infinity.
    assign total = {{(TOT_W-ROW_W-FW){lo_l_reg[ROW_W-1]}}, lo_l_reg, {FW{1'b0}}}
                 + {{(TOT_W-P1_W-FW){p1_reg[P1_W-1]}}, p1_reg, {FW{1'b0}}}
                 + {{(TOT_W-2*FW){1'b0}}, p0_reg};

    // Valid flags of the four inner stages and the output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[2:0], vld_in};
            out_vld_reg <= vld_reg[3];
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h00_reg    <= corners.h00;
            h01_reg    <= corners.h01;
            dlo_reg    <= dlo_next;
            dhi_reg    <= dhi_next;
            tx_i_reg   <= tx;
            ty_i_reg   <= ty;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            ty_j_reg   <= ty_i_reg;
            lo_k_reg   <= lo_reg;
            dd_reg     <= dd_next;
            ty_k_reg   <= ty_j_reg;
            lo_l_reg   <= lo_k_reg;
            p1_reg     <= p1_next;
            p0_reg     <= p0_next;
            height_reg <= total[RES_LO+HW-1:RES_LO];
        end
    end

    assign vld_out = out_vld_reg;
    assign height  = $signed(height_reg);

endmodule
